@@ design/scba_pkg.sv @@
package scba_pkg;

  // Pool geometry
  localparam int NUM_CLASSES = 6;
  localparam int CLASS_DEPTH = 1024;
  localparam int CLASS_REGS  = 6;

  // Field widths
  localparam int SIZE_W  = 16;
  localparam int PSIZE_W = SIZE_W + 1;
  localparam int CLASS_W = 3;
  localparam int SLOT_W  = 10;
  localparam int CNT_W   = 11;
  localparam int LINK_W  = SLOT_W + 1;

  // Link memory geometry
  localparam int LINK_DEPTH = NUM_CLASSES * CLASS_DEPTH;
  localparam int LINK_AW    = $clog2(LINK_DEPTH);
  localparam int POOL_IW    = $clog2(NUM_CLASSES);
  localparam int CREG_IW    = $clog2(CLASS_REGS);

  // Rounding mask for pool sizes
  localparam logic [PSIZE_W-1:0] ROUND_ADD  = PSIZE_W'(3);
  localparam logic [PSIZE_W-1:0] ROUND_MASK = ~PSIZE_W'(3);

  typedef enum logic [1:0] {
    OP_ALLOC      = 2'd0,
    OP_FREE       = 2'd1,
    OP_REALLOC    = 2'd2,
    OP_FREE_ALLOC = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NULL    = 2'd1,
    ST_NOBUF   = 2'd2,
    ST_BADPOOL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_CLASS0  = 3'd0,
    REG_CLASS1  = 3'd1,
    REG_CLASS2  = 3'd2,
    REG_CLASS3  = 3'd3,
    REG_CLASS4  = 3'd4,
    REG_CLASS5  = 3'd5,
    REG_BUFFERS = 3'd6,
    REG_CLASSES = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_POP,
    S_PUSH,
    S_FINISH
  } state_t;

  // Result item as it leaves on the master side
  typedef struct packed {
    logic [SIZE_W-1:0]  copy_bytes;
    logic [SLOT_W-1:0]  result_slot;
    logic [CLASS_W-1:0] result_class;
    logic               result_present;
    status_t            status;
  } result_t;

  // Rounded buffer size of a pool; pools past the register set never fit
  function automatic logic [PSIZE_W-1:0] pool_size(
    input logic [SIZE_W-1:0]  cls_bytes [CLASS_REGS],
    input logic [CLASS_W-1:0] p
  );
    logic [PSIZE_W-1:0] sz;
    sz = '0;
    if (32'(p) < CLASS_REGS) begin
      sz = (PSIZE_W'(cls_bytes[CREG_IW'(p)]) + ROUND_ADD) & ROUND_MASK;
    end
    return sz;
  endfunction

  // Flat link memory address of a pool/slot pair
  function automatic logic [LINK_AW-1:0] link_addr(
    input logic [CLASS_W-1:0] p,
    input logic [SLOT_W-1:0]  s
  );
    return LINK_AW'(LINK_AW'(p) * LINK_AW'(CLASS_DEPTH)) + LINK_AW'(s);
  endfunction

endpackage

@@ design/scba_ram.sv @@
module scba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/size_class_buffer_pool_allocator.sv @@
// Channel   Dir  Width  Contents
// apb       in   32     psel/penable/pwrite/paddr/pwdata, prdata out, pready tied high
// s_axis    in   32+2   request item: tdata payload, tuser operation
// m_axis    out  32     result item: status, handle, copy length
//
// An item passes through decode, a scan of one pool per cycle through the shared
// size compare (with a further step when the scan runs past the last pool), a
// link memory read on a list pop, a push write, the load of the output register,
// and the idle state in which the next item is taken.
// s_tready is high only when the sequencer is idle; a finished result waits in
// the output register while the next item is accepted.
// Reset clears pool heads, list flags and fresh counters at once; the link
// memory needs no clearing since entries are read only after a free wrote them.
module size_class_buffer_pool_allocator (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request items
  input  logic        s_tvalid,
  output logic        s_tready,
  // request_bytes[15:0], handle_present[16], handle_class[19:17], handle_slot[29:20]
  input  logic [31:0] s_tdata,
  // operation[1:0]
  input  logic [1:0]  s_tuser,
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[1:0], result_present[2], result_class[5:3], result_slot[15:6],
  // copy_bytes[31:16]
  output logic [31:0] m_tdata
);
  import scba_pkg::*;

  // Configuration registers
  logic [SIZE_W-1:0] class_bytes [CLASS_REGS];
  logic [CNT_W-1:0]  buffers_per_class;
  logic [2:0]        classes_in_use;

  // Pool state
  logic [SLOT_W-1:0] head          [NUM_CLASSES];
  logic [SLOT_W-1:0] head_next     [NUM_CLASSES];
  logic              nonempty      [NUM_CLASSES];
  logic              nonempty_next [NUM_CLASSES];
  logic [CNT_W-1:0]  fresh         [NUM_CLASSES];
  logic [CNT_W-1:0]  fresh_next    [NUM_CLASSES];

  // Captured request
  op_t                op_q;
  logic [SIZE_W-1:0]  size_q;
  logic               hp_q;
  logic [CLASS_W-1:0] hc_q;
  logic [SLOT_W-1:0]  hs_q;

  // Sequencer
  state_t             state, state_next;
  logic [CLASS_W-1:0] idx, idx_next;
  logic               tried, tried_next;
  result_t            res, res_next;
  result_t            m_data;
  logic               m_valid_next;
  result_t            m_data_next;
  logic               go_alloc;
  logic               alloc_ok;

  // Link memory port
  logic               ram_we;
  logic [LINK_AW-1:0] ram_waddr;
  logic [LINK_W-1:0]  ram_wdata;
  logic [LINK_AW-1:0] ram_raddr;
  logic [LINK_W-1:0]  ram_rdata;

  // Shared size unit
  logic [CLASS_W-1:0] sel_pool;
  logic [PSIZE_W-1:0] psize;
  logic               fits;

  logic [2:0]         n_pools;
  logic [CNT_W-1:0]   pool_cnt;
  logic               hc_valid;
  logic               accept;
  reg_idx_t           widx;
  reg_idx_t           ridx;

  assign pready   = 1'b1;
  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign m_tdata  = m_data;

  // Saturated register views
  assign n_pools  = (32'(classes_in_use) > NUM_CLASSES) ? 3'(NUM_CLASSES) : classes_in_use;
  assign pool_cnt = (32'(buffers_per_class) > CLASS_DEPTH) ? CNT_W'(CLASS_DEPTH)
                                                           : buffers_per_class;
  assign hc_valid = hc_q < n_pools;

  // Shared compare: rounded pool size against the request
  assign sel_pool = (state == S_SCAN) ? idx : hc_q;
  assign psize    = pool_size(class_bytes, sel_pool);
  assign fits     = psize >= PSIZE_W'(size_q);

  // Configuration write
  assign widx = reg_idx_t'(paddr[4:2]);
  always_ff @(posedge clk) begin
    if (rst) begin
      class_bytes[0]    <= SIZE_W'(16);
      class_bytes[1]    <= SIZE_W'(32);
      class_bytes[2]    <= SIZE_W'(64);
      class_bytes[3]    <= SIZE_W'(160);
      class_bytes[4]    <= SIZE_W'(320);
      class_bytes[5]    <= SIZE_W'(2200);
      buffers_per_class <= CNT_W'(1024);
      classes_in_use    <= 3'd6;
    end else if (psel && penable && pwrite) begin
      unique case (widx) inside
        REG_CLASS0, REG_CLASS1, REG_CLASS2,
        REG_CLASS3, REG_CLASS4, REG_CLASS5: begin
          class_bytes[CREG_IW'(widx)] <= pwdata[SIZE_W-1:0];
        end
        REG_BUFFERS: buffers_per_class <= pwdata[CNT_W-1:0];
        REG_CLASSES: classes_in_use    <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // Configuration read
  assign ridx = reg_idx_t'(paddr[4:2]);
  always_comb begin
    unique case (ridx) inside
      REG_CLASS0, REG_CLASS1, REG_CLASS2,
      REG_CLASS3, REG_CLASS4, REG_CLASS5: prdata = 32'(class_bytes[CREG_IW'(ridx)]);
      REG_BUFFERS: prdata = 32'(buffers_per_class);
      REG_CLASSES: prdata = 32'(classes_in_use);
      default:     prdata = '0;
    endcase
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= op_t'(s_tuser);
      size_q <= s_tdata[15:0];
      hp_q   <= s_tdata[16];
      hc_q   <= s_tdata[19:17];
      hs_q   <= s_tdata[29:20];
    end
  end

  // Link memory: {next exists, next slot}
  scba_ram #(
    .WIDTH (LINK_W),
    .DEPTH (LINK_DEPTH)
  ) u_link (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      idx      <= '0;
      tried    <= 1'b0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head[i]     <= '0;
        nonempty[i] <= 1'b0;
        fresh[i]    <= '0;
      end
    end else begin
      state    <= state_next;
      idx      <= idx_next;
      tried    <= tried_next;
      m_tvalid <= m_valid_next;
      head     <= head_next;
      nonempty <= nonempty_next;
      fresh    <= fresh_next;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    res    <= res_next;
    m_data <= m_data_next;
  end

  // Next state and datapath control
  always_comb begin
    state_next    = state;
    idx_next      = idx;
    tried_next    = tried;
    res_next      = res;
    head_next     = head;
    nonempty_next = nonempty;
    fresh_next    = fresh;
    m_valid_next  = m_tvalid && !m_tready;
    m_data_next   = m_data;
    go_alloc      = 1'b0;
    alloc_ok      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = link_addr(hc_q, hs_q);
    ram_wdata     = '0;
    ram_raddr     = '0;

    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          res_next   = '{copy_bytes: '0, result_slot: '0, result_class: '0,
                         result_present: 1'b0, status: ST_NULL};
          state_next = S_DECODE;
        end
      end

      S_DECODE: begin
        unique case (op_q)
          OP_ALLOC: go_alloc = 1'b1;
          OP_FREE: begin
            if (!hp_q) begin
              res_next.status = ST_NULL;
              state_next      = S_FINISH;
            end else if (!hc_valid) begin
              res_next.status = ST_BADPOOL;
              state_next      = S_FINISH;
            end else begin
              res_next.status = ST_OK;
              state_next      = S_PUSH;
            end
          end
          OP_REALLOC: begin
            if (!hp_q) begin
              go_alloc = 1'b1;
            end else if (size_q == '0) begin
              // zero size frees the handle
              res_next.status = hc_valid ? ST_NULL : ST_BADPOOL;
              state_next      = hc_valid ? S_PUSH : S_FINISH;
            end else if (!hc_valid) begin
              res_next.status = ST_BADPOOL;
              state_next      = S_FINISH;
            end else if (fits) begin
              // fits in place: same handle back
              res_next.status         = ST_OK;
              res_next.result_present = 1'b1;
              res_next.result_class   = hc_q;
              res_next.result_slot    = hs_q;
              state_next              = S_FINISH;
            end else begin
              idx_next   = '0;
              tried_next = 1'b0;
              state_next = S_SCAN;
            end
          end
          OP_FREE_ALLOC: begin
            if (hp_q && hc_valid) begin
              state_next = S_PUSH;
            end else begin
              go_alloc = 1'b1;
            end
          end
          default: ;
        endcase
      end

      // One pool per cycle through the shared compare
      S_SCAN: begin
        if (idx >= n_pools) begin
          res_next.status = ST_NOBUF;
          state_next      = S_FINISH;
        end else if (fits) begin
          if (nonempty[POOL_IW'(idx)]) begin
            ram_raddr  = link_addr(idx, head[POOL_IW'(idx)]);
            state_next = S_POP;
          end else if (fresh[POOL_IW'(idx)] < pool_cnt) begin
            res_next.result_class          = idx;
            res_next.result_slot           = fresh[POOL_IW'(idx)][SLOT_W-1:0];
            fresh_next[POOL_IW'(idx)]      = fresh[POOL_IW'(idx)] + CNT_W'(1);
            alloc_ok                       = 1'b1;
          end else if (idx == n_pools - 3'd1 || tried) begin
            res_next.status = ST_NOBUF;
            state_next      = S_FINISH;
          end else begin
            tried_next = 1'b1;
            idx_next   = idx + CLASS_W'(1);
          end
        end else begin
          idx_next = idx + CLASS_W'(1);
        end
      end

      // Pop the free list head with the link just read
      S_POP: begin
        res_next.result_class        = idx;
        res_next.result_slot         = head[POOL_IW'(idx)];
        head_next[POOL_IW'(idx)]     = ram_rdata[SLOT_W-1:0];
        nonempty_next[POOL_IW'(idx)] = ram_rdata[SLOT_W];
        alloc_ok                     = 1'b1;
      end

      // Push the given handle onto its pool's list
      S_PUSH: begin
        if (32'(hs_q) < CLASS_DEPTH) begin
          ram_we    = 1'b1;
          ram_wdata = {nonempty[POOL_IW'(hc_q)], head[POOL_IW'(hc_q)]};
          head_next[POOL_IW'(hc_q)]     = hs_q;
          nonempty_next[POOL_IW'(hc_q)] = 1'b1;
        end
        if (op_q == OP_REALLOC && res.status == ST_OK) begin
          res_next.copy_bytes = psize[SIZE_W-1:0];
        end
        if (op_q == OP_FREE_ALLOC) begin
          go_alloc = 1'b1;
        end else begin
          state_next = S_FINISH;
        end
      end

      S_FINISH: begin
        if (!m_tvalid || m_tready) begin
          m_valid_next = 1'b1;
          m_data_next  = res;
          state_next   = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase

    // Start of an alloc scan, or a null result for a zero size
    if (go_alloc) begin
      if (size_q == '0) begin
        res_next.status = ST_NULL;
        state_next      = S_FINISH;
      end else begin
        idx_next   = '0;
        tried_next = 1'b0;
        state_next = S_SCAN;
      end
    end

    // Buffer taken; a moving realloc then frees the old handle
    if (alloc_ok) begin
      res_next.status         = ST_OK;
      res_next.result_present = 1'b1;
      state_next              = (op_q == OP_REALLOC && hp_q) ? S_PUSH : S_FINISH;
    end
  end

endmodule

@@ design/scba_checker.sv @@
module scba_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // One item at a time: ready drops right after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted while busy");

  // No handle means zero class, slot and copy length
  a_null: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[2] |-> m_tdata[15:3] == 13'd0 && m_tdata[31:16] == 16'd0)
    else $error("null result carries a handle");

  // A returned handle only comes with an ok status
  a_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> m_tdata[1:0] == 2'd0)
    else $error("handle returned with error status");

endmodule

bind size_class_buffer_pool_allocator scba_checker u_scba_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
